/* hw/rtl/spectrum_bar_level_peak_hold_defines.svh */
// ----------------------------------------------------------------------------
// Spectrum bar level with peak hold - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_LEVEL_PEAK_HOLD_DEFINES_SVH
`define SPECTRUM_BAR_LEVEL_PEAK_HOLD_DEFINES_SVH

// same-cycle implication
`define SBLPH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBLPH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sblph_pkg.sv */
// ----------------------------------------------------------------------------
// sblph_pkg
// Types and constants shared by the spectrum bar level / peak hold block.
// ----------------------------------------------------------------------------
package sblph_pkg;

	localparam int BAR_W  = 6;
	localparam int DB_W   = 16;
	localparam int FRAC_W = 16;
	localparam int AGE_W  = 8;

	localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

	// 80 dB span in Q8.8; norm = d * 16 / 5 through a reciprocal multiply
	localparam logic [DB_W-1:0] NORM_SPAN  = 16'd20480;
	localparam logic [19:0]     NORM_RECIP = 20'd838861;
	localparam int              NORM_SHIFT = 22;

	localparam int WORK_Q_DEPTH = 4;
	localparam int RES_Q_DEPTH  = 4;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic signed [DB_W-1:0] FLOOR_DB_RST    = -16'sd20480;
	localparam logic [FRAC_W-1:0]      SMOOTH_RST      = 16'd22938;
	localparam logic [AGE_W-1:0]       HOLD_ITEMS_RST  = 8'd25;
	localparam logic [FRAC_W-1:0]      PEAK_DECAY_RST  = 16'd62259;

	typedef enum logic [1:0] {
		REG_FLOOR_DB   = 2'd0,
		REG_SMOOTH     = 2'd1,
		REG_HOLD_ITEMS = 2'd2,
		REG_PEAK_DECAY = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DB_W-1:0] floor_db;
		logic [FRAC_W-1:0]      smooth_factor;
		logic [AGE_W-1:0]       peak_hold_items;
		logic [FRAC_W-1:0]      peak_decay;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [BAR_W-1:0]  bar;
		logic              in_range;
		logic [FRAC_W-1:0] norm;
	} work_t;

	typedef struct packed {
		logic [BAR_W-1:0]  bar_out;
		logic [FRAC_W-1:0] level;
		logic [FRAC_W-1:0] peak;
	} res_t;

endpackage

/* hw/rtl/sblph_if.sv */
// ----------------------------------------------------------------------------
// sblph_if
// Valid/ready channels for bar samples and bar results.
// ----------------------------------------------------------------------------
interface sblph_sample_if;
	logic              valid;
	logic              ready;
	logic [5:0]        bar;
	logic signed [15:0] raw_db;

	modport source (output valid, output bar, output raw_db, input ready);
	modport sink   (input valid, input bar, input raw_db, output ready);
endinterface

interface sblph_result_if;
	logic        valid;
	logic        ready;
	logic [5:0]  bar_out;
	logic [15:0] level;
	logic [15:0] peak;

	modport source (output valid, output bar_out, output level, output peak, input ready);
	modport sink   (input valid, input bar_out, input level, input peak, output ready);
endinterface

/* hw/rtl/sblph_ram.sv */
// ----------------------------------------------------------------------------
// sblph_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module sblph_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

/* hw/rtl/sblph_fifo.sv */
// ----------------------------------------------------------------------------
// sblph_fifo
// Small flop-based first-in first-out queue with fill count.
// ----------------------------------------------------------------------------
module sblph_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty,
	output logic [CW-1:0]    count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/sblph_cfg.sv */
// ----------------------------------------------------------------------------
// sblph_cfg
// APB register file: dB floor, smoothing factor, peak hold count, peak decay.
// ----------------------------------------------------------------------------
module sblph_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sblph_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sblph_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sblph_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output sblph_pkg::cfg_t                  cfg
);
	import sblph_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_db        <= FLOOR_DB_RST;
			cfg_q.smooth_factor   <= SMOOTH_RST;
			cfg_q.peak_hold_items <= HOLD_ITEMS_RST;
			cfg_q.peak_decay      <= PEAK_DECAY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FLOOR_DB:   cfg_q.floor_db        <= $signed(pwdata[DB_W-1:0]);
				REG_SMOOTH:     cfg_q.smooth_factor   <= pwdata[FRAC_W-1:0];
				REG_HOLD_ITEMS: cfg_q.peak_hold_items <= pwdata[AGE_W-1:0];
				REG_PEAK_DECAY: cfg_q.peak_decay      <= pwdata[FRAC_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FLOOR_DB:   prdata = APB_DATA_W'(cfg_q.floor_db);
			REG_SMOOTH:     prdata = APB_DATA_W'(cfg_q.smooth_factor);
			REG_HOLD_ITEMS: prdata = APB_DATA_W'(cfg_q.peak_hold_items);
			REG_PEAK_DECAY: prdata = APB_DATA_W'(cfg_q.peak_decay);
		endcase
	end

endmodule

/* hw/rtl/sblph_front.sv */
// ----------------------------------------------------------------------------
// sblph_front
// Accepts bar samples, checks the bar index and normalizes the dB value to a
// Q0.16 fraction of the 80 dB span above the floor.
// ----------------------------------------------------------------------------
module sblph_front #(
	parameter int BAR_COUNT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sblph_sample_if.sink                  sample,
	input  logic signed [sblph_pkg::DB_W-1:0] floor_db,
	output logic                          wq_push,
	output sblph_pkg::work_t              wq_data,
	input  logic                          wq_full
);
	import sblph_pkg::*;

	logic signed [DB_W:0] diff;
	logic [DB_W-1:0]      d;
	logic [DB_W+3:0]      d_x16;
	logic [DB_W+23:0]     prod;
	logic [FRAC_W-1:0]    norm;
	logic                 accept;

	logic  s1_valid_q;
	work_t item_s1;

	// clip at the floor: a negative distance is zero
	assign diff = $signed({sample.raw_db[DB_W-1], sample.raw_db})
		- $signed({floor_db[DB_W-1], floor_db});
	assign d     = diff[DB_W] ? '0 : diff[DB_W-1:0];
	assign d_x16 = {d, 4'b0000};
	assign prod  = d_x16 * NORM_RECIP;
	assign norm  = (d >= NORM_SPAN) ? {FRAC_W{1'b1}} : prod[NORM_SHIFT+FRAC_W-1:NORM_SHIFT];

	assign sample.ready = !s1_valid_q || !wq_full;
	assign accept       = sample.valid && sample.ready;
	assign wq_push      = s1_valid_q && !wq_full;
	assign wq_data      = item_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.bar      <= sample.bar;
			item_s1.in_range <= (int'(sample.bar) < BAR_COUNT);
			item_s1.norm     <= norm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (wq_push) begin
			s1_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/sblph_back.sv */
// ----------------------------------------------------------------------------
// sblph_back
// Per-bar read-modify-write: level average in the first stage, peak hold and
// decay in the second, with forwarding and a credited result queue.
// ----------------------------------------------------------------------------
`include "spectrum_bar_level_peak_hold_defines.svh"

module sblph_back #(
	parameter int BAR_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sblph_pkg::cfg_t  cfg,
	input  logic             wq_empty,
	input  sblph_pkg::work_t wq_data,
	output logic             wq_pop,
	sblph_result_if.source   result
);
	import sblph_pkg::*;

	localparam int AW    = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
	localparam int OQ_CW = $clog2(RES_Q_DEPTH + 1);
	localparam int PK_W  = FRAC_W + AGE_W;

	// result queue
	logic             oq_push;
	logic             oq_pop;
	res_t             oq_in;
	res_t             oq_out;
	logic             oq_full;
	logic             oq_empty;
	logic [OQ_CW-1:0] oq_count;
	logic [OQ_CW:0]   in_flight;

	// stage 1: level
	logic              b1_valid_q;
	work_t             item_b1;
	logic              lvl_vld_b1;
	logic [FRAC_W-1:0] lvl_rd;
	logic [FRAC_W-1:0] old_lvl;
	logic signed [FRAC_W:0]     lvl_diff;
	logic signed [2*FRAC_W+1:0] lvl_prod;
	logic [FRAC_W-1:0] lvl_new;
	logic              lvl_we;
	logic              lvl_fwd;
	logic [BAR_COUNT-1:0] lvl_vld_q;

	// stage 2: peak
	logic              b2_valid_q;
	work_t             item_b2;
	logic [FRAC_W-1:0] level_b2;
	logic              pk_vld_b2;
	logic [PK_W-1:0]   pk_rd;
	logic [FRAC_W-1:0] old_peak;
	logic [AGE_W-1:0]  old_age;
	logic [2*FRAC_W-1:0] decay_prod;
	logic [AGE_W-1:0]  age_inc;
	logic [FRAC_W-1:0] new_peak;
	logic [AGE_W-1:0]  new_age;
	logic              pk_we;
	logic              pk_fwd;
	logic [BAR_COUNT-1:0] pk_vld_q;

	// last peak write, kept for the next item, whose RAM read does not yet see it
	logic              last_valid_q;
	logic [BAR_W-1:0]  last_bar_q;
	logic [FRAC_W-1:0] last_peak_q;
	logic [AGE_W-1:0]  last_age_q;

	logic [AW-1:0] head_addr;
	logic [AW-1:0] b1_addr;
	logic [AW-1:0] b2_addr;

	assign head_addr = AW'(wq_data.bar);
	assign b1_addr   = AW'(item_b1.bar);
	assign b2_addr   = AW'(item_b2.bar);

	// pop only with room reserved for every item still in the pipeline
	assign in_flight = {1'b0, oq_count} + (OQ_CW+1)'(b1_valid_q) + (OQ_CW+1)'(b2_valid_q);
	assign wq_pop    = !wq_empty && (in_flight < (OQ_CW+1)'(RES_Q_DEPTH));

	// ---------------- stage 1 ----------------
	sblph_ram #(.WIDTH(FRAC_W), .DEPTH(BAR_COUNT), .AW(AW)) u_level_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (b1_addr),
		.wdata (lvl_new),
		.raddr (head_addr),
		.rdata (lvl_rd)
	);

	assign lvl_fwd = b2_valid_q && item_b2.in_range && (item_b2.bar == item_b1.bar);

	always_comb begin
		if (lvl_fwd) begin
			old_lvl = level_b2;
		end else if (lvl_vld_b1) begin
			old_lvl = lvl_rd;
		end else begin
			old_lvl = '0;
		end
	end

	// level = old + floor(s * (norm - old) / 2^16)
	assign lvl_diff = $signed({1'b0, item_b1.norm}) - $signed({1'b0, old_lvl});
	assign lvl_prod = $signed({1'b0, cfg.smooth_factor}) * lvl_diff;
	assign lvl_new  = old_lvl + lvl_prod[2*FRAC_W-1:FRAC_W];
	assign lvl_we   = b1_valid_q && item_b1.in_range;

	always_ff @(posedge clk) begin
		lvl_vld_b1 <= lvl_vld_q[head_addr];
		if (wq_pop) begin
			item_b1 <= wq_data;
		end
		if (b1_valid_q) begin
			item_b2  <= item_b1;
			level_b2 <= lvl_new;
		end
	end

	// ---------------- stage 2 ----------------
	sblph_ram #(.WIDTH(PK_W), .DEPTH(BAR_COUNT), .AW(AW)) u_peak_ram (
		.clk   (clk),
		.we    (pk_we),
		.waddr (b2_addr),
		.wdata ({new_peak, new_age}),
		.raddr (b1_addr),
		.rdata (pk_rd)
	);

	assign pk_fwd = last_valid_q && (last_bar_q == item_b2.bar);

	always_comb begin
		if (pk_fwd) begin
			old_peak = last_peak_q;
			old_age  = last_age_q;
		end else if (pk_vld_b2) begin
			old_peak = pk_rd[PK_W-1:AGE_W];
			old_age  = pk_rd[AGE_W-1:0];
		end else begin
			old_peak = '0;
			old_age  = '0;
		end
	end

	assign decay_prod = old_peak * cfg.peak_decay;
	assign age_inc    = (old_age == AGE_MAX) ? old_age : old_age + AGE_W'(1);

	always_comb begin
		if (level_b2 >= old_peak) begin
			new_peak = level_b2;
			new_age  = '0;
		end else begin
			new_age  = age_inc;
			new_peak = (age_inc > cfg.peak_hold_items) ?
				decay_prod[2*FRAC_W-1:FRAC_W] : old_peak;
		end
	end

	assign pk_we = b2_valid_q && item_b2.in_range;

	always_ff @(posedge clk) begin
		pk_vld_b2 <= pk_vld_q[b1_addr];
		if (pk_we) begin
			last_bar_q  <= item_b2.bar;
			last_peak_q <= new_peak;
			last_age_q  <= new_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q   <= 1'b0;
			b2_valid_q   <= 1'b0;
			last_valid_q <= 1'b0;
			lvl_vld_q    <= '0;
			pk_vld_q     <= '0;
		end else begin
			b1_valid_q   <= wq_pop;
			b2_valid_q   <= b1_valid_q;
			last_valid_q <= pk_we;
			if (lvl_we) begin
				lvl_vld_q[b1_addr] <= 1'b1;
			end
			if (pk_we) begin
				pk_vld_q[b2_addr] <= 1'b1;
			end
		end
	end

	// ---------------- result queue ----------------
	assign oq_push       = b2_valid_q;
	assign oq_in.bar_out = item_b2.bar;
	assign oq_in.level   = item_b2.in_range ? level_b2 : '0;
	assign oq_in.peak    = item_b2.in_range ? new_peak : '0;

	sblph_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_Q_DEPTH), .CW(OQ_CW)) u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (oq_push),
		.push_data (oq_in),
		.pop       (oq_pop),
		.pop_data  (oq_out),
		.full      (oq_full),
		.empty     (oq_empty),
		.count     (oq_count)
	);

	assign result.valid   = !oq_empty;
	assign oq_pop         = result.valid && result.ready;
	assign result.bar_out = oq_out.bar_out;
	assign result.level   = oq_out.level;
	assign result.peak    = oq_out.peak;

	`SBLPH_ASSERT_NOW(a_res_q_room, oq_push, !oq_full || oq_pop, "result queue overflow")
	`SBLPH_ASSERT_NOW(a_credit_bound, 1'b1, in_flight <= (OQ_CW+1)'(RES_Q_DEPTH), "credit exceeded")
	`SBLPH_ASSERT_NEXT(a_b1_fill, wq_pop, b1_valid_q, "popped item missing in stage 1")
	`SBLPH_ASSERT_NEXT(a_b2_fill, b1_valid_q, b2_valid_q && oq_push, "stage 1 item lost")

endmodule

/* hw/rtl/spectrum_bar_level_peak_hold.sv */
// Path: a sample's result passes the front stage, work queue, level stage, peak stage and
// result queue, each registered, before it is valid.
// Throughput: one sample per cycle while results are taken, back to back on any bar mix; the
// level and peak read-modify-write loops forward the previous write so repeated bars do not stall.
// Reset: config returns to its defaults, queues empty, and per-bar valid bits clear so every
// bar's level, peak and age read as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// spectrum_bar_level_peak_hold
// Smoothed spectrum bar level with peak hold and decay, per bar index.
// ----------------------------------------------------------------------------
module spectrum_bar_level_peak_hold #(
	parameter int BAR_COUNT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sblph_sample_if.sink                     sample,
	sblph_result_if.source                   result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sblph_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sblph_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sblph_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import sblph_pkg::*;

	localparam int WQ_CW = $clog2(WORK_Q_DEPTH + 1);

	cfg_t             cfg;
	logic             wq_push;
	work_t            wq_in;
	logic             wq_pop;
	work_t            wq_out;
	logic             wq_full;
	logic             wq_empty;
	logic [WQ_CW-1:0] wq_count;

	sblph_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sblph_front #(.BAR_COUNT(BAR_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.floor_db (cfg.floor_db),
		.wq_push  (wq_push),
		.wq_data  (wq_in),
		.wq_full  (wq_full)
	);

	sblph_fifo #(.WIDTH($bits(work_t)), .DEPTH(WORK_Q_DEPTH), .CW(WQ_CW)) u_work_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (wq_push),
		.push_data (wq_in),
		.pop       (wq_pop),
		.pop_data  (wq_out),
		.full      (wq_full),
		.empty     (wq_empty),
		.count     (wq_count)
	);

	sblph_back #(.BAR_COUNT(BAR_COUNT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.wq_empty (wq_empty),
		.wq_data  (wq_out),
		.wq_pop   (wq_pop),
		.result   (result)
	);

	`include "spectrum_bar_level_peak_hold_defines.svh"

	`SBLPH_ASSERT_NOW(a_wq_count, wq_push, wq_count < WQ_CW'(WORK_Q_DEPTH), "work queue overflow")
	`SBLPH_ASSERT_NOW(a_wq_pop, wq_pop, wq_count != '0, "work queue underflow")
	`SBLPH_ASSERT_NEXT(a_wq_fill, wq_push && !wq_pop, wq_count != '0, "pushed item not counted")

endmodule
